// ----- rtl/core/wbps_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_pkg
// shared types and constants of the wildcard byte pattern scanner
// ---------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int OFFSET_BITS     = 32;
    localparam int REG_BYTES       = 16;
    localparam int PAT_CAP         = (MAX_PATTERN_LEN < REG_BYTES) ? MAX_PATTERN_LEN
                                                                   : REG_BYTES;
    localparam int LEN_W           = 5;
    localparam int PIDX_W          = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int MASK_W          = 16;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [7:0]             byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_WILDCARD = 2'd2,
        CFG_LENGTH   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic    found;
        offset_t offset;
    } result_t;

endpackage

// ----- rtl/core/wbps_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_cell
// one window byte: shifts in from its neighbour (the stream for the head
// cell) and compares the incoming byte with its aligned pattern byte
// ---------------------------------------------------------------------------
module wbps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  wbps_pkg::cell_ctl_t ctl,
    input  wbps_pkg::byte_t     byte_in,
    input  wbps_pkg::byte_t     pat_byte,
    input  logic                care,
    output wbps_pkg::byte_t     byte_out,
    output logic                hit
);

    wbps_pkg::byte_t byte_reg;
    wbps_pkg::byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            byte_next = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !care || (byte_in == pat_byte);

endmodule

// ----- rtl/core/wbps_out_skid.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_out_skid
// output register with one skid entry between the scan and the result bus
// ---------------------------------------------------------------------------
module wbps_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  wbps_pkg::result_t res,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wbps_pkg::result_t m_res
);

    logic              out_valid_reg;
    logic              out_valid_next;
    wbps_pkg::result_t out_res_reg;
    wbps_pkg::result_t out_res_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    wbps_pkg::result_t skid_res_reg;
    wbps_pkg::result_t skid_res_next;
    logic              pop;

    assign pop = out_valid_reg && m_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_res_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output on pop");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && in_ready && out_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

// ----- rtl/core/wildcard_byte_pattern_scanner.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// streams image bytes through a row of window cells and reports the first
// offset where the wildcard pattern matches, or not-found at image end
// ---------------------------------------------------------------------------
// channel | direction | handshake          | payload
// s       | in        | s_tvalid/s_tready  | tdata image_byte, tlast end_of_image
// m       | out       | m_tvalid/m_tready  | tdata match_offset, tuser found
// cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//
// one byte per cycle while s_tready is high; the window cells compare in the
// cycle a byte is taken and shift until a match; the result is registered
// s_tready falls only when the output register and its skid entry are full
// reset clears window, byte count, done flag and result valid flags at once
// ---------------------------------------------------------------------------
module wildcard_byte_pattern_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // image_byte
    input  logic                                s_tlast,   // end_of_image
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wbps_pkg::OFFSET_BITS-1:0]    m_tdata,   // match_offset
    output logic [0:0]                          m_tuser,   // found
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int NCELL = wbps_pkg::MAX_PATTERN_LEN;
    localparam wbps_pkg::offset_t COUNT_MAX = '1;

    logic [63:0]                   pat_lo_reg;
    logic [63:0]                   pat_hi_reg;
    logic [wbps_pkg::MASK_W-1:0]   wild_reg;
    wbps_pkg::len_t                len_reg;
    wbps_pkg::len_t                len_wr;
    wbps_pkg::offset_t             count_reg;
    wbps_pkg::offset_t             count_next;
    logic                          done_reg;
    logic                          done_next;

    logic [8*wbps_pkg::REG_BYTES-1:0] pat_all;
    wbps_pkg::byte_t               cell_pat [NCELL];
    logic [NCELL-1:0]              cell_care;
    wbps_pkg::byte_t               cell_q [NCELL];
    logic [NCELL-1:0]              cell_hit;
    wbps_pkg::cell_ctl_t           ctl;

    logic                          accept;
    logic                          step;
    logic                          enough;
    logic                          match;
    logic                          res_valid;
    wbps_pkg::result_t             res;
    wbps_pkg::result_t             m_res;
    wbps_pkg::len_t                len_m1;
    wbps_pkg::offset_t             ofs;

    // configuration
    always_comb
    begin
        len_wr = cfg_wdata[wbps_pkg::LEN_W-1:0];
        if (len_wr == '0)
        begin
            len_wr = wbps_pkg::len_t'(1);
        end
        else if (len_wr > wbps_pkg::len_t'(wbps_pkg::PAT_CAP))
        begin
            len_wr = wbps_pkg::len_t'(wbps_pkg::PAT_CAP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            len_reg    <= wbps_pkg::len_t'(1);
        end
        else if (cfg_we)
        begin
            unique case (wbps_pkg::cfg_idx_t'(cfg_index))
                wbps_pkg::CFG_PAT_LOW:  pat_lo_reg <= cfg_wdata[63:0];
                wbps_pkg::CFG_PAT_HIGH: pat_hi_reg <= cfg_wdata[63:0];
                wbps_pkg::CFG_WILDCARD: wild_reg   <= cfg_wdata[wbps_pkg::MASK_W-1:0];
                wbps_pkg::CFG_LENGTH:   len_reg    <= len_wr;
                default:                ;
            endcase
        end
    end

    // pattern byte aligned to each cell
    assign pat_all = {pat_hi_reg, pat_lo_reg};

    always_comb
    begin
        wbps_pkg::len_t k;
        for (int i = 0; i < NCELL; i++)
        begin
            k            = len_reg - wbps_pkg::len_t'(i) - wbps_pkg::len_t'(1);
            cell_pat[i]  = pat_all[k[wbps_pkg::PIDX_W-1:0]*8 +: 8];
            cell_care[i] = (i < int'(len_reg)) && !wild_reg[k[wbps_pkg::PIDX_W-1:0]];
        end
    end

    assign accept    = s_tvalid && s_tready;
    assign step      = accept && !done_reg;
    assign ctl.shift = step;
    assign ctl.clear = accept && s_tlast;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                wbps_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .byte_in  (s_tdata),
                    .pat_byte (cell_pat[g]),
                    .care     (cell_care[g]),
                    .byte_out (cell_q[g]),
                    .hit      (cell_hit[g])
                );
            end
            else
            begin : g_body
                wbps_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl),
                    .byte_in  (cell_q[g-1]),
                    .pat_byte (cell_pat[g]),
                    .care     (cell_care[g]),
                    .byte_out (cell_q[g]),
                    .hit      (cell_hit[g])
                );
            end
        end
    endgenerate

    // offset of a match, from the count before this byte
    assign len_m1 = len_reg - wbps_pkg::len_t'(1);
    assign enough = count_reg >= wbps_pkg::offset_t'(len_m1);
    assign ofs    = (count_reg >= COUNT_MAX - wbps_pkg::offset_t'(1))
                  ? COUNT_MAX
                  : count_reg - wbps_pkg::offset_t'(len_m1);
    assign match  = step && enough && (&cell_hit);

    assign res_valid  = match || (step && s_tlast);
    assign res.found  = match;
    assign res.offset = match ? ofs : '0;

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (accept && s_tlast)
        begin
            count_next = '0;
            done_next  = 1'b0;
        end
        else
        begin
            if (step && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + wbps_pkg::offset_t'(1);
            end
            if (match)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    wbps_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = m_res.offset;
    assign m_tuser = m_res.found;

    a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done_reg |-> !res_valid)
        else $error("result raised after match already reported");

    a_match_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        match && !s_tlast |=> done_reg)
        else $error("done flag not set after match");

    a_fresh_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (count_reg == '0) && !done_reg)
        else $error("scan state not cleared after final word");

endmodule

// ----- tb/sv/wbps_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbps_checker
// watches the config port and both stream channels of the scanner, keeps its
// own copy of the window, byte count and done flag, predicts the found or
// not-found word of every image and compares each output word in order
// ---------------------------------------------------------------------------
module wbps_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // image_byte
    input  logic                             s_tlast,   // end_of_image
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [wbps_pkg::OFFSET_BITS-1:0] m_tdata,   // match_offset
    input  logic [0:0]                       m_tuser,   // found
    input  logic                             cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               pending,
    output int                               fail_count
);

    wbps_pkg::result_t expected_results[$];
    wbps_pkg::byte_t   scan_window[wbps_pkg::MAX_PATTERN_LEN];
    wbps_pkg::offset_t scan_count;
    logic              scan_hit;
    logic [63:0]       pat_low;
    logic [63:0]       pat_high;
    logic [15:0]       any_mask;
    wbps_pkg::len_t    len_reg;
    int                mismatches;

    function automatic int active_length();
        int n;
        n = int'(len_reg);
        if (n == 0)
            n = 1;
        if (n > wbps_pkg::PAT_CAP)
            n = wbps_pkg::PAT_CAP;
        return n;
    endfunction

    function automatic wbps_pkg::byte_t pattern_at(int k);
        if (k < 8)
            return pat_low[8*k +: 8];
        return pat_high[8*(k-8) +: 8];
    endfunction

    function automatic bit window_hit(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (any_mask[k])
                continue;
            if (scan_window[n-1-k] != pattern_at(k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_scan();
        int i;
        for (i = 0; i < wbps_pkg::MAX_PATTERN_LEN; i++)
            scan_window[i] = '0;
        scan_count = '0;
        scan_hit   = 1'b0;
    endtask

    task automatic take_byte(wbps_pkg::byte_t b, logic last);
        int                n;
        int                i;
        wbps_pkg::result_t r;
        if (!scan_hit)
        begin
            n = active_length();
            for (i = wbps_pkg::MAX_PATTERN_LEN - 1; i > 0; i--)
                scan_window[i] = scan_window[i-1];
            scan_window[0] = b;
            if (scan_count != '1)
                scan_count = scan_count + 1'b1;
            if (scan_count >= wbps_pkg::offset_t'(n) && window_hit(n))
            begin
                r.found  = 1'b1;
                // saturated count reports all ones
                r.offset = (scan_count == '1) ? '1 : scan_count - wbps_pkg::offset_t'(n);
                expected_results = {expected_results, r};
                scan_hit = 1'b1;
            end
            else if (last)
            begin
                r.found  = 1'b0;
                r.offset = '0;
                expected_results = {expected_results, r};
            end
        end
        if (last)
            clear_scan();
    endtask

    always @(posedge clk)
    begin
        wbps_pkg::result_t got;
        wbps_pkg::result_t want;
        if (!rst_n)
        begin
            pat_low    = '0;
            pat_high   = '0;
            any_mask   = '0;
            len_reg    = wbps_pkg::len_t'(1);
            mismatches = 0;
            expected_results.delete();
            clear_scan();
        end
        else
        begin
            if (cfg_we)
            begin
                case (wbps_pkg::cfg_idx_t'(cfg_index))
                    wbps_pkg::CFG_PAT_LOW:  pat_low  = cfg_wdata;
                    wbps_pkg::CFG_PAT_HIGH: pat_high = cfg_wdata;
                    wbps_pkg::CFG_WILDCARD: any_mask = cfg_wdata[wbps_pkg::MASK_W-1:0];
                    wbps_pkg::CFG_LENGTH:   len_reg  = cfg_wdata[wbps_pkg::LEN_W-1:0];
                    default:                ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.found  = m_tuser[0];
                got.offset = m_tdata;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual found=%0b offset=%0h",
                             $time, got.found, got.offset);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        mismatches++;
                    end
                    if (got.offset !== want.offset)
                    begin
                        $display("%0t: match_offset mismatch: expected %0h, actual %0h",
                                 $time, want.offset, got.offset);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tlast);
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives images of bytes into the scanner under a series of pattern, wildcard
// and length settings: directed corner cases first, then random images, most
// with the pattern planted, with random gaps on both sides and one long
// output stall; the checker beside the block does the comparing
// ---------------------------------------------------------------------------
module tb_top;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;   // image_byte
    logic                             s_tlast   = 1'b0; // end_of_image
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [wbps_pkg::OFFSET_BITS-1:0] m_tdata;          // match_offset
    logic [0:0]                       m_tuser;          // found
    logic                             cfg_we    = 1'b0;
    logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int              pending;
    int              fail_count;
    int              tx_idle_max = 18;
    bit              hold_req    = 1'b0;
    int              bytes_sent  = 0;
    wbps_pkg::byte_t pat[16];
    logic [15:0]     mask_now = '0;
    int              len_now  = 1;

    always #1 clk = ~clk;

    wildcard_byte_pattern_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    wbps_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    task automatic write_reg(wbps_pkg::cfg_idx_t idx, logic [63:0] value);
        int k;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            wbps_pkg::CFG_PAT_LOW:  for (k = 0; k < 8; k++) pat[k] = value[8*k +: 8];
            wbps_pkg::CFG_PAT_HIGH: for (k = 0; k < 8; k++) pat[8+k] = value[8*k +: 8];
            wbps_pkg::CFG_WILDCARD: mask_now = value[15:0];
            wbps_pkg::CFG_LENGTH:   len_now = (value[4:0] == 0) ? 1
                                            : (value[4:0] > 16) ? 16 : int'(value[4:0]);
            default:                ;
        endcase
    endtask

    task automatic send_byte(wbps_pkg::byte_t b, bit last);
        int gap;
        gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random image of n bytes, optionally with the pattern planted somewhere
    task automatic scan_image(int n, bit plant);
        wbps_pkg::byte_t img[$];
        wbps_pkg::byte_t b;
        int              i;
        int              pos;
        for (i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 1) == 0) ? pat[$urandom_range(0, 15)]
                                             : wbps_pkg::byte_t'($urandom_range(0, 255));
            img = {img, b};
        end
        if (plant && n >= len_now)
        begin
            pos = $urandom_range(0, n - len_now);
            for (i = 0; i < len_now; i++)
                if (!mask_now[i])
                    img[pos+i] = pat[i];
        end
        for (i = 0; i < n; i++)
            send_byte(img[i], i == n - 1);
    endtask

    task automatic random_phase(int idx);
        logic [63:0] mk;
        logic [63:0] ln;
        int          start;
        mk = {$urandom, $urandom};
        ln = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       mk[15:0] = 16'h0000;
            1:       mk[15:0] = 16'hFFFF;
            2:       mk[15:0] = 16'($urandom & $urandom);
            default: ;
        endcase
        case (idx)
            0:       ln[4:0] = 5'd16;
            1:       ln[4:0] = 5'd1;
            2:       ln[4:0] = 5'd0;
            3:       ln[4:0] = 5'd31;
            default: ln[4:0] = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(1, 6));
        endcase
        write_reg(wbps_pkg::CFG_PAT_LOW, {$urandom, $urandom});
        write_reg(wbps_pkg::CFG_PAT_HIGH, {$urandom, $urandom});
        write_reg(wbps_pkg::CFG_WILDCARD, mk);
        write_reg(wbps_pkg::CFG_LENGTH, ln);
        tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
        start = bytes_sent;
        while (bytes_sent - start < 100)
            scan_image($urandom_range(1, len_now + 12), $urandom_range(0, 3) != 0);
        drain();
    endtask

    // output side: random gaps, runs with none, and one long hold on request
    initial
    begin
        int gap;
        int words;
        int rx_idle_max;
        words       = 0;
        rx_idle_max = 18;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (words % 40 == 0)
                    rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
                gap = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            words++;
        end
    end

    initial
    begin
        int phase;
        int i;
        for (i = 0; i < 16; i++)
            pat[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single zero byte pattern
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        write_reg(wbps_pkg::CFG_PAT_LOW, 64'h0000_0000_DDCC_BBAA);
        write_reg(wbps_pkg::CFG_WILDCARD, 64'h0000_0000_0000_0004);
        write_reg(wbps_pkg::CFG_LENGTH, 64'd4);
        // match then bytes ignored up to the end of the image
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hDD, 1'b0);
        send_byte(8'h55, 1'b1);
        // image shorter than the pattern
        send_byte(8'hAA, 1'b1);
        // wildcard dropped part way through an image
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
        write_reg(wbps_pkg::CFG_WILDCARD, 64'h0);
        send_byte(8'hDD, 1'b1);
        // match ending on the final byte
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'hDD, 1'b1);
        drain();
        // length zero acts as one
        write_reg(wbps_pkg::CFG_LENGTH, 64'd0);
        send_byte(8'hAA, 1'b1);
        drain();
        // length above the cap acts as sixteen
        write_reg(wbps_pkg::CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(wbps_pkg::CFG_WILDCARD, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(wbps_pkg::CFG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        for (i = 0; i < 16; i++)
            send_byte(i[0] ? 8'hFF : 8'h00, i == 15);
        drain();

        phase = 0;
        while (bytes_sent < 1400)
        begin
            random_phase(phase);
            phase++;
            if (phase == 5)
            begin
                // one-byte images, each giving a word, against a stalled output
                write_reg(wbps_pkg::CFG_WILDCARD, 64'h0000_0000_0000_FFFF);
                write_reg(wbps_pkg::CFG_LENGTH, 64'd1);
                tx_idle_max = 0;
                hold_req    = 1'b1;
                for (i = 0; i < 40; i++)
                    send_byte(wbps_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
                drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[wildcard_byte_pattern_scanner] OK");
        else
            $display("[wildcard_byte_pattern_scanner] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[wildcard_byte_pattern_scanner] ERROR");
        $finish;
    end

endmodule
